/* rtl/itp_pkg.sv */
package itp_pkg;

    typedef enum logic [2:0] {
        OP_LPAR = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       run_last;
        logic       expr_end;
        t_status    status;
    } t_res;

    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_MOD  = 8'h25;

    function automatic logic [7:0] op_char(t_op c);
        logic [7:0] r;
        unique case (c)
            OP_LPAR: r = CH_LPAR;
            OP_ADD:  r = CH_ADD;
            OP_SUB:  r = CH_SUB;
            OP_MUL:  r = CH_MUL;
            OP_DIV:  r = CH_DIV;
            OP_MOD:  r = CH_MOD;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] op_prec(t_op c);
        logic [1:0] r;
        unique case (c)
            OP_ADD, OP_SUB:         r = 2'd1;
            OP_MUL, OP_DIV, OP_MOD: r = 2'd2;
            default:                r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_op(logic [7:0] ch);
        return (ch == CH_ADD) || (ch == CH_SUB) || (ch == CH_MUL) ||
               (ch == CH_DIV) || (ch == CH_MOD);
    endfunction

    function automatic t_op op_of(logic [7:0] ch);
        t_op r;
        unique case (ch)
            CH_ADD:  r = OP_ADD;
            CH_SUB:  r = OP_SUB;
            CH_MUL:  r = OP_MUL;
            CH_DIV:  r = OP_DIV;
            CH_MOD:  r = OP_MOD;
            default: r = OP_LPAR;
        endcase
        return r;
    endfunction

endpackage

/* rtl/itp_ram.sv */
module itp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/itp_ctrl.sv */
module itp_ctrl import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [7:0]                     i_char_in,
    input  logic                           i_expr_last,
    output logic                           o_busy,
    input  logic                           i_out_free,
    output logic                           o_emit,
    output t_res                           o_res,
    output logic                           o_we,
    output logic [$clog2(STACK_DEPTH)-1:0] o_waddr,
    output logic [2:0]                     o_wdata,
    output logic                           o_re,
    output logic [$clog2(STACK_DEPTH)-1:0] o_raddr,
    input  logic [2:0]                     i_rdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_UND, S_FIN} t_state;
    typedef enum logic [1:0] {M_OP, M_PAR, M_FLUSH} t_mode;

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    t_op           r_code, n_code;
    logic          r_last, n_last;
    logic [CW-1:0] r_count, n_count;
    t_res          r_pend, n_pend;
    logic          r_pend_v, n_pend_v;

    logic          put, do_push, do_after, fin_emit, blocked;
    t_res          put_res, emit_res;
    t_op           push_code, top;
    logic [CW-1:0] pc, cm1;
    logic          we, re;
    logic [AW-1:0] wa;

    assign top = t_op'(i_rdata);
    assign cm1 = r_count - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_code    = r_code;
        n_last    = r_last;
        n_count   = r_count;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        put       = 1'b0;
        put_res   = '0;
        do_push   = 1'b0;
        do_after  = 1'b0;
        fin_emit  = 1'b0;
        push_code = OP_LPAR;
        pc        = r_count;
        we        = 1'b0;
        wa        = '0;
        re        = 1'b0;
        emit_res  = r_pend;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_expr_last;
                    priority if (is_op(i_char_in)) begin
                        n_code = op_of(i_char_in);
                        if (r_count != '0) begin
                            n_mode  = M_OP;
                            n_state = S_RD;
                        end else begin
                            do_push   = 1'b1;
                            push_code = op_of(i_char_in);
                            do_after  = 1'b1;
                        end
                    end else if (i_char_in == CH_LPAR) begin
                        do_push   = 1'b1;
                        push_code = OP_LPAR;
                        do_after  = 1'b1;
                    end else if (i_char_in == CH_RPAR) begin
                        if (r_count != '0) begin
                            n_mode  = M_PAR;
                            n_state = S_RD;
                        end else begin
                            put            = 1'b1;
                            put_res.status = ST_UNDER;
                            do_after       = 1'b1;
                        end
                    end else begin
                        put           = 1'b1;
                        put_res.ch    = i_char_in;
                        put_res.valid = 1'b1;
                        do_after      = 1'b1;
                    end
                end
            end
            S_RD: begin
                re      = 1'b1;
                n_state = S_EV;
            end
            S_EV: begin
                unique case (r_mode)
                    M_OP: begin
                        if (op_prec(top) >= op_prec(r_code)) begin
                            put           = 1'b1;
                            put_res.ch    = op_char(top);
                            put_res.valid = 1'b1;
                            n_count       = cm1;
                            if (cm1 != '0) begin
                                n_state = S_RD;
                            end else begin
                                pc        = cm1;
                                do_push   = 1'b1;
                                push_code = r_code;
                                do_after  = 1'b1;
                            end
                        end else begin
                            do_push   = 1'b1;
                            push_code = r_code;
                            do_after  = 1'b1;
                        end
                    end
                    M_PAR: begin
                        n_count = cm1;
                        if (top == OP_LPAR) begin
                            do_after = 1'b1;
                        end else begin
                            put           = 1'b1;
                            put_res.ch    = op_char(top);
                            put_res.valid = 1'b1;
                            n_state       = (cm1 != '0) ? S_RD : S_UND;
                        end
                    end
                    default: begin
                        put           = 1'b1;
                        put_res.ch    = op_char(top);
                        put_res.valid = 1'b1;
                        n_count       = cm1;
                        n_state       = (cm1 != '0) ? S_RD : S_FIN;
                    end
                endcase
            end
            S_UND: begin
                put            = 1'b1;
                put_res.status = ST_UNDER;
                do_after       = 1'b1;
            end
            default: begin
                fin_emit = r_pend_v || r_last;
                if (r_pend_v) begin
                    emit_res = r_pend;
                end else begin
                    emit_res = '0;
                end
                emit_res.run_last = 1'b1;
                emit_res.expr_end = r_last;
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end
        endcase

        if (do_push) begin
            if (pc == FULL) begin
                put            = 1'b1;
                put_res        = '0;
                put_res.status = ST_OVER;
                n_count        = '0;
            end else begin
                we      = 1'b1;
                wa      = pc[AW-1:0];
                n_count = pc + CW'(1);
            end
        end

        if (do_after) begin
            if (n_last && n_count != '0) begin
                n_mode  = M_FLUSH;
                n_state = S_RD;
            end else begin
                n_state = S_FIN;
            end
        end

        if (put) begin
            n_pend   = put_res;
            n_pend_v = 1'b1;
        end

        blocked = ((put && r_pend_v) || fin_emit) && !i_out_free;
        if (blocked) begin
            n_state  = r_state;
            n_mode   = r_mode;
            n_code   = r_code;
            n_last   = r_last;
            n_count  = r_count;
            n_pend   = r_pend;
            n_pend_v = r_pend_v;
            we       = 1'b0;
            re       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
        r_mode <= n_mode;
        r_code <= n_code;
        r_last <= n_last;
        r_pend <= n_pend;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_emit  = ((put && r_pend_v) || fin_emit) && !blocked;
    assign o_res   = emit_res;
    assign o_we    = we;
    assign o_waddr = wa;
    assign o_wdata = push_code;
    assign o_re    = re;
    assign o_raddr = cm1[AW-1:0];

endmodule

/* rtl/infix_to_postfix_converter.sv */
// Infix to postfix converter (shunting yard).
// Input channel: i_in_valid / o_in_stall, one expression character per beat
// with i_expr_last on the final character of an expression.
// Output channel: o_out_valid / i_out_stall, one postfix character per beat,
// with o_char_valid, o_run_last (last beat caused by an input beat),
// o_expr_end (last beat of an expression) and o_status (ok, unmatched ')',
// stack overflow; an error beat has o_char_valid low and clears the stack).
// The operator stack lives in a single-port-read RAM of STACK_DEPTH entries.
// Each input beat passes through the idle state and then a finish state; each
// stack entry popped or flushed adds a RAM read state followed by an evaluate
// state. An operator that stops at a lower-precedence entry also reads that
// entry, and an unmatched ')' adds an error-beat state. Output stalls add to
// this. One result is held back until the next is known, so the last beat of
// a run appears at the end of that input's processing.
// Input is taken only while the controller is idle; a stalled output holds
// the output register and the controller waits once it has a beat to move.
// Reset (synchronous, active low) empties the stack and drops pending beats;
// RAM contents are not cleared.
module infix_to_postfix_converter import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_expr_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_run_last,
    output logic       o_expr_end,
    output logic [1:0] o_status
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic          busy, emit, out_free;
    t_res          res, r_out;
    logic          r_out_v;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [2:0]    wdata, rdata;

    assign out_free = !r_out_v || !i_out_stall;

    itp_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_char_in   (i_char_in),
        .i_expr_last (i_expr_last),
        .o_busy      (busy),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    itp_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (emit) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_v;
    assign o_char_out   = r_out.ch;
    assign o_char_valid = r_out.valid;
    assign o_run_last   = r_out.run_last;
    assign o_expr_end   = r_out.expr_end;
    assign o_status     = r_out.status;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("beat moved into a full output register");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("controller idle right after taking a beat");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_expr_end) |-> o_run_last)
        else $error("expression end without run end");

    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_char_valid) |-> (o_status == ST_OK))
        else $error("character beat carries an error status");

endmodule

/* bench/postfix_checker.sv */
module postfix_checker import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_expr_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_char_out,
    input  logic       i_char_valid,
    input  logic       i_run_last,
    input  logic       i_expr_end,
    input  logic [1:0] i_status,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_beats_out,
    output int         o_under_count,
    output int         o_over_count
);

    t_op  op_stack [STACK_DEPTH];
    int   depth_now  = 0;
    t_res postfix_q [$];
    int   fails      = 0;
    int   beats_out  = 0;
    int   under_seen = 0;
    int   over_seen  = 0;

    function automatic logic [7:0] char_of(t_op c);
        case (c)
            OP_ADD:  return CH_ADD;
            OP_SUB:  return CH_SUB;
            OP_MUL:  return CH_MUL;
            OP_DIV:  return CH_DIV;
            OP_MOD:  return CH_MOD;
            default: return CH_LPAR;
        endcase
    endfunction

    function automatic int rank_of(t_op c);
        case (c)
            OP_ADD, OP_SUB:         return 1;
            OP_MUL, OP_DIV, OP_MOD: return 2;
            default:                return 0;
        endcase
    endfunction

    task automatic emit(input logic [7:0] ch, input logic v, input t_status st);
        t_res r;
        r.ch       = ch;
        r.valid    = v;
        r.run_last = 1'b0;
        r.expr_end = 1'b0;
        r.status   = st;
        postfix_q.push_back(r);
    endtask

    task automatic push_op(input t_op c);
        if (depth_now >= STACK_DEPTH) begin
            depth_now = 0;
            over_seen++;
            emit(8'h00, 1'b0, ST_OVER);
        end else begin
            op_stack[depth_now] = c;
            depth_now++;
        end
    endtask

    // one input beat of the shunting-yard conversion; queues the beats it yields
    task automatic convert_char(input logic [7:0] ch, input logic last);
        int   start;
        bit   is_op;
        bit   found;
        t_op  oc;
        t_op  top;
        t_res tail;
        start = postfix_q.size();
        is_op = 1'b1;
        oc    = OP_LPAR;
        case (ch)
            CH_ADD:  oc = OP_ADD;
            CH_SUB:  oc = OP_SUB;
            CH_MUL:  oc = OP_MUL;
            CH_DIV:  oc = OP_DIV;
            CH_MOD:  oc = OP_MOD;
            default: is_op = 1'b0;
        endcase
        if (is_op) begin
            while (depth_now > 0 && rank_of(op_stack[depth_now - 1]) >= rank_of(oc)) begin
                emit(char_of(op_stack[depth_now - 1]), 1'b1, ST_OK);
                depth_now--;
            end
            push_op(oc);
        end else if (ch == CH_LPAR) begin
            push_op(OP_LPAR);
        end else if (ch == CH_RPAR) begin
            found = 1'b0;
            while (depth_now > 0 && !found) begin
                top = op_stack[depth_now - 1];
                depth_now--;
                if (top == OP_LPAR) begin
                    found = 1'b1;
                end else begin
                    emit(char_of(top), 1'b1, ST_OK);
                end
            end
            if (!found) begin
                under_seen++;
                emit(8'h00, 1'b0, ST_UNDER);
            end
        end else begin
            emit(ch, 1'b1, ST_OK);
        end
        if (last) begin
            while (depth_now > 0) begin
                emit(char_of(op_stack[depth_now - 1]), 1'b1, ST_OK);
                depth_now--;
            end
            if (postfix_q.size() == start) begin
                emit(8'h00, 1'b0, ST_OK);
            end
        end
        if (postfix_q.size() > start) begin
            tail = postfix_q.pop_back();
            tail.run_last = 1'b1;
            tail.expr_end = last;
            postfix_q.push_back(tail);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            postfix_q.delete();
            depth_now = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                beats_out++;
                if (postfix_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected beat, expected none, actual ch=%h valid=%b st=%0d",
                             $time, i_char_out, i_char_valid, i_status);
                end else begin
                    want = postfix_q.pop_front();
                    check_field("char_out", want.ch, i_char_out);
                    check_field("char_valid", 8'(want.valid), 8'(i_char_valid));
                    check_field("run_last", 8'(want.run_last), 8'(i_run_last));
                    check_field("expr_end", 8'(want.expr_end), 8'(i_expr_end));
                    check_field("status", 8'(want.status), 8'(i_status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                convert_char(i_char_in, i_expr_last);
            end
        end
        o_fail_count  <= fails;
        o_pending     <= postfix_q.size();
        o_beats_out   <= beats_out;
        o_under_count <= under_seen;
        o_over_count  <= over_seen;
    end

endmodule

/* bench/tb.sv */
module tb import itp_pkg::*; ();

    localparam int STACK_DEPTH = 32;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_char_in   = 8'h00;
    logic       i_expr_last = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_char_out;
    logic       o_char_valid;
    logic       o_run_last;
    logic       o_expr_end;
    logic [1:0] o_status;

    int         fail_count;
    int         pending;
    int         beats_out;
    int         under_count;
    int         over_count;
    int         sent       = 0;
    int         exprs      = 0;
    int         stall_left = 0;
    bit         idle_on    = 1'b0;
    logic [7:0] toks [$];

    infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_in   (i_char_in),
        .i_expr_last (i_expr_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_out  (o_char_out),
        .o_char_valid(o_char_valid),
        .o_run_last  (o_run_last),
        .o_expr_end  (o_expr_end),
        .o_status    (o_status)
    );

    postfix_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_char_in    (i_char_in),
        .i_expr_last  (i_expr_last),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_char_out   (o_char_out),
        .i_char_valid (o_char_valid),
        .i_run_last   (o_run_last),
        .i_expr_end   (o_expr_end),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beats_out  (beats_out),
        .o_under_count(under_count),
        .o_over_count (over_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("** infix_to_postfix_converter: FAILED **");
        $finish;
    end

    // output backpressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] random_op();
        case ($urandom_range(0, 4))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_MOD;
        endcase
    endfunction

    function automatic logic [7:0] random_operand();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV ||
                   c == CH_MOD || c == CH_LPAR || c == CH_RPAR);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_in   <= ch;
        i_expr_last <= last;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        if (last) begin
            exprs++;
        end
    endtask

    task automatic send_toks(input bit close);
        for (int i = 0; i < toks.size(); i++) begin
            send_char(toks[i], close && (i == toks.size() - 1));
        end
        toks.delete();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly well-formed expression; sloppy adds stray parens or operators
    task automatic build_expr(input bit sloppy);
        int  nest;
        int  len;
        int  limit;
        bit  want_operand;
        nest         = 0;
        want_operand = 1'b1;
        len          = $urandom_range(1, 14);
        limit        = $urandom_range(0, 4);
        while (toks.size() < 64) begin
            if (want_operand) begin
                if (nest < limit && toks.size() < len && $urandom_range(0, 2) == 0) begin
                    toks.push_back(CH_LPAR);
                    nest++;
                end else begin
                    toks.push_back(random_operand());
                    want_operand = 1'b0;
                end
            end else if (nest > 0 && (toks.size() >= len || $urandom_range(0, 3) == 0)) begin
                toks.push_back(CH_RPAR);
                nest--;
            end else if (nest == 0 && (toks.size() >= len || $urandom_range(0, 5) == 0)) begin
                break;
            end else begin
                toks.push_back(random_op());
                want_operand = 1'b1;
            end
        end
        if (sloppy) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 2))
                    0:       toks.insert($urandom_range(0, toks.size()), CH_RPAR);
                    1:       toks.insert($urandom_range(0, toks.size()), CH_LPAR);
                    default: toks.insert($urandom_range(0, toks.size()), random_op());
                endcase
            end
        end
    endtask

    // nested groups that only push, to fill the stack to a given depth
    task automatic build_deep(input int target, input bit tail_operand);
        int pushes;
        pushes = 0;
        while (pushes < target) begin
            toks.push_back(CH_LPAR);
            pushes++;
            if (pushes < target && $urandom_range(0, 1) == 1) begin
                toks.push_back(random_operand());
                toks.push_back(random_op());
                pushes++;
            end
        end
        if (tail_operand) begin
            toks.push_back(random_operand());
        end
    endtask

    initial begin
        int kind;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CH_RPAR, 1'b0);
        send_char("a", 1'b0);
        send_char(CH_ADD, 1'b0);
        send_char("b", 1'b0);
        send_char(CH_MUL, 1'b0);
        send_char("c", 1'b0);
        send_char(CH_SUB, 1'b0);
        send_char("d", 1'b0);
        send_char(CH_DIV, 1'b0);
        send_char("e", 1'b0);
        send_char(CH_MOD, 1'b0);
        send_char("f", 1'b1);
        send_char(CH_LPAR, 1'b0);
        send_char(CH_LPAR, 1'b0);
        send_char("x", 1'b0);
        send_char(CH_ADD, 1'b0);
        send_char("y", 1'b0);
        send_char(CH_RPAR, 1'b0);
        send_char(CH_RPAR, 1'b1);
        send_char(CH_SUB, 1'b0);
        send_char(CH_LPAR, 1'b1);
        send_char(CH_ADD, 1'b0);
        send_char(CH_RPAR, 1'b1);
        drain();

        // overflow on the final char, then a full stack flushed by one operand
        build_deep(STACK_DEPTH + 1, 1'b0);
        send_toks(1'b1);
        build_deep(STACK_DEPTH, 1'b1);
        send_toks(1'b1);

        while (sent < 200) begin
            idle_on = (sent < 170) && ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 19);
            if (kind == 0) begin
                build_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3),
                           $urandom_range(0, 1));
                send_toks(1'b1);
            end else if (kind <= 2) begin
                repeat ($urandom_range(1, 6)) toks.push_back(8'($urandom_range(0, 255)));
                send_toks($urandom_range(0, 1));
            end else begin
                build_expr(kind <= 4);
                send_toks(1'b1);
            end
            if ($urandom_range(0, 15) == 0) begin
                drain();
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("Converted %0d chars in %0d expressions, %0d postfix beats checked,",
                 sent, exprs, beats_out);
        $display("with %0d unmatched ')' and %0d stack overflow errors.",
                 under_count, over_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** infix_to_postfix_converter: PASSED **");
        end else begin
            $display("** infix_to_postfix_converter: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/itp_pkg.sv
rtl/itp_ram.sv
rtl/itp_ctrl.sv
rtl/infix_to_postfix_converter.sv
bench/postfix_checker.sv
bench/tb.sv
